### hw/rtl/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

    // Default pool depth of the built tables.
    localparam int NUM_SLOTS_DEF = 256;

    // Widths of the interface fields.
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 8;
    localparam int POOL_W  = 9;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    // Pool size register value after reset.
    localparam logic [POOL_W-1:0] POOL_SIZE_RST = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_command;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_ALREADY   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR1,
        S_FREE_WR2,
        S_CLEAR,
        S_NOP
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ALLOC,
        RES_FREE_ERR,
        RES_FREE_OK,
        RES_CLEAR,
        RES_NOP
    } t_res_sel;

    typedef struct packed {
        logic     latch_in;
        logic     rd_alloc;
        logic     rd_free;
        logic     wr_free_a;
        logic     wr_free_b;
        logic     sweep_wr;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic free_err;
        logic sweep_last;
    } t_dp_sts;

endpackage

### hw/rtl/dense_slot_allocator_core.sv
`timescale 1ns / 1ps
// The result strobe is registered from the last step of each command; busy falls as the
// strobe rises, so the block takes no new command until the previous one has reported.
// The steps follow from the single-port order and position tables and their registered reads.
// Reset (synchronous, active low) starts a pass that rewrites both tables to identity with
// busy high; no strobe is given for it. Results cannot be held off by the receiver.

module dense_slot_allocator_core
    import dsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [POOL_W-1:0]    i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [SLOT_W-1:0]    i_slot_index,
    output logic                 o_strobe,
    output logic [SLOT_W-1:0]    o_granted_slot,
    output logic [STAT_W-1:0]    o_status,
    output logic [COUNT_W-1:0]   o_in_use_count
);

    // The controller walks each command through its table steps and tells the datapath
    // which read or write port to drive in each cycle. The datapath owns the tables, the
    // in-use count, the pool size register and the result registers.
    //
    // Allocate reads the order table at the count, then records the slot's position and
    // bumps the count. Free reads the slot's position and the last used slot together,
    // then swaps the two entries in two write steps. A slot counts as free when its
    // position is at or beyond the in-use count, so no separate flag store is kept.
    // Clear sweeps every entry back to identity, one entry per cycle, and reports once
    // the final entry is written.

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    dsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd),
        .busy      (busy)
    );

    dsa_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_slot_index   (i_slot_index),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_strobe       (o_strobe),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status),
        .o_in_use_count (o_in_use_count)
    );

endmodule

### hw/rtl/dsa_ctrl.sv
`timescale 1ns / 1ps

module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [CMD_W-1:0]     i_command,
    input  t_dp_sts              i_sts,
    output t_dp_cmd              o_cmd,
    output logic                 busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (t_command'(i_command))
                        CMD_ALLOC: n_state = S_ALLOC_RD;
                        CMD_FREE:  n_state = S_FREE_RD;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_NOP;
                    endcase
                end
            end
            S_ALLOC_RD: n_state = S_ALLOC_WR;
            S_ALLOC_WR: n_state = S_IDLE;
            S_FREE_RD:  n_state = S_FREE_WR1;
            S_FREE_WR1: begin
                n_state = i_sts.free_err ? S_IDLE : S_FREE_WR2;
            end
            S_FREE_WR2: n_state = S_IDLE;
            S_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_NOP:   n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_cmd.res_sel = RES_NONE;
        busy = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
            end
            S_IDLE: begin
                busy = 1'b0;
                o_cmd.latch_in = start;
            end
            S_ALLOC_RD: begin
                o_cmd.rd_alloc = 1'b1;
            end
            S_ALLOC_WR: begin
                o_cmd.res_sel = RES_ALLOC;
            end
            S_FREE_RD: begin
                o_cmd.rd_free = 1'b1;
            end
            S_FREE_WR1: begin
                if (i_sts.free_err) begin
                    o_cmd.res_sel = RES_FREE_ERR;
                end else begin
                    o_cmd.wr_free_a = 1'b1;
                end
            end
            S_FREE_WR2: begin
                o_cmd.wr_free_b = 1'b1;
                o_cmd.res_sel = RES_FREE_OK;
            end
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.res_sel = RES_CLEAR;
                end
            end
            S_NOP: begin
                o_cmd.res_sel = RES_NOP;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/dsa_datapath.sv
`timescale 1ns / 1ps

module dsa_datapath
    import dsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [POOL_W-1:0]    i_cfg_wdata,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_strobe,
    output logic [SLOT_W-1:0]    o_granted_slot,
    output logic [STAT_W-1:0]    o_status,
    output logic [COUNT_W-1:0]   o_in_use_count
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);
    localparam logic [31:0]   NUM_SLOTS_32 = 32'(NUM_SLOTS);

    // Order table and its inverse, the position table.
    logic [AW-1:0] r_order_mem [NUM_SLOTS];
    logic [AW-1:0] r_pos_mem   [NUM_SLOTS];

    logic [POOL_W-1:0]  r_pool_size;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      n_used;
    logic [AW-1:0]      r_sweep;
    logic [SLOT_W-1:0]  r_slot;
    logic [AW-1:0]      r_ord_rd;
    logic [AW-1:0]      r_pos_rd;

    logic               r_strobe;
    logic [SLOT_W-1:0]  r_granted;
    logic [STAT_W-1:0]  r_status;
    logic [COUNT_W-1:0] r_count;

    logic [31:0]   pool32;
    logic [31:0]   size32;
    logic [CW-1:0] size_eff;
    logic [31:0]   slot32;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] used_addr;
    logic [CW-1:0] used_m1;
    logic [AW-1:0] last_addr;
    logic          alloc_full;
    logic          slot_big;
    logic          alloc_ok;
    logic [31:0]   granted32;
    logic [31:0]   count32;

    logic          ord_we;
    logic [AW-1:0] ord_waddr;
    logic [AW-1:0] ord_wdata;
    logic          ord_re;
    logic [AW-1:0] ord_raddr;
    logic          pos_we;
    logic [AW-1:0] pos_waddr;
    logic [AW-1:0] pos_wdata;

    // Pool size clamped to 1..NUM_SLOTS.
    always_comb begin
        pool32 = 32'(r_pool_size);
        if (pool32 == 32'd0) begin
            size32 = 32'd1;
        end else if (pool32 > NUM_SLOTS_32) begin
            size32 = NUM_SLOTS_32;
        end else begin
            size32 = pool32;
        end
        size_eff = size32[CW-1:0];
    end

    assign slot32     = 32'(r_slot);
    assign slot_addr  = slot32[AW-1:0];
    assign used_addr  = r_used[AW-1:0];
    assign used_m1    = r_used - CW'(1);
    assign last_addr  = used_m1[AW-1:0];
    assign alloc_full = (r_used >= size_eff);
    assign slot_big   = (slot32 >= size32);
    assign alloc_ok   = (i_cmd.res_sel == RES_ALLOC) && !alloc_full;

    // An in-range slot is free exactly when its position is at or beyond the count.
    assign o_sts.free_err   = slot_big || (CW'(r_pos_rd) >= r_used);
    assign o_sts.sweep_last = (r_sweep == LAST_ADDR);

    // Table port selection.
    always_comb begin
        ord_we    = 1'b0;
        ord_waddr = r_sweep;
        ord_wdata = r_sweep;
        pos_we    = 1'b0;
        pos_waddr = r_sweep;
        pos_wdata = r_sweep;
        if (i_cmd.sweep_wr) begin
            ord_we = 1'b1;
            pos_we = 1'b1;
        end else if (alloc_ok) begin
            pos_we    = 1'b1;
            pos_waddr = r_ord_rd;
            pos_wdata = used_addr;
        end else if (i_cmd.wr_free_a) begin
            ord_we    = 1'b1;
            ord_waddr = last_addr;
            ord_wdata = slot_addr;
            pos_we    = 1'b1;
            pos_waddr = slot_addr;
            pos_wdata = last_addr;
        end else if (i_cmd.wr_free_b) begin
            ord_we    = 1'b1;
            ord_waddr = r_pos_rd;
            ord_wdata = r_ord_rd;
            pos_we    = 1'b1;
            pos_waddr = r_ord_rd;
            pos_wdata = r_pos_rd;
        end
    end

    assign ord_re    = i_cmd.rd_alloc || i_cmd.rd_free;
    assign ord_raddr = i_cmd.rd_alloc ? used_addr : last_addr;

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_order_mem[ord_waddr] <= ord_wdata;
        end
        if (ord_re) begin
            r_ord_rd <= r_order_mem[ord_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_waddr] <= pos_wdata;
        end
        if (i_cmd.rd_free) begin
            r_pos_rd <= r_pos_mem[slot_addr];
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_cmd.sweep_wr) begin
            n_used = '0;
        end else if (alloc_ok) begin
            n_used = r_used + CW'(1);
        end else if (i_cmd.res_sel == RES_FREE_OK) begin
            n_used = used_m1;
        end
    end

    assign granted32 = 32'(r_ord_rd);
    assign count32   = 32'(n_used);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_SIZE_RST;
            r_used      <= '0;
            r_sweep     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool_size <= i_cfg_wdata;
            end
            r_used <= n_used;
            if (i_cmd.sweep_wr) begin
                r_sweep <= (r_sweep == LAST_ADDR) ? '0 : r_sweep + AW'(1);
            end
            r_strobe <= (i_cmd.res_sel != RES_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_slot <= i_slot_index;
        end
        if (i_cmd.res_sel != RES_NONE) begin
            r_count   <= count32[COUNT_W-1:0];
            r_granted <= alloc_ok ? granted32[SLOT_W-1:0] : '0;
            case (i_cmd.res_sel)
                RES_ALLOC:    r_status <= alloc_full ? ST_FULL : ST_OK;
                RES_FREE_ERR: r_status <= slot_big ? ST_RANGE : ST_ALREADY;
                default:      r_status <= ST_OK;
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_granted_slot = r_granted;
    assign o_status       = r_status;
    assign o_in_use_count = r_count;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dsa_pkg::*;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;

    // Command code 3 is not decoded by the block and behaves as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // The slowest legal run is roughly 1600 beats, each waiting out the longest gap and a full
    // clear sweep, plus the sweep after reset. The limit below is several times that figure.
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int SCRIPT_LEN = 27;
    localparam int NUM_PHASES = 8;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [SLOT_W-1:0]  granted;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_alloc_outcome;

    // One row of the directed script: either a pool size write or a command beat, the latter
    // optionally carrying a result that is written in by hand.
    typedef struct packed {
        bit                 is_cfg;
        logic [POOL_W-1:0]  cfg_value;
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        bit                 typed;
        t_alloc_outcome     want;
    } t_script_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [POOL_W-1:0]    i_cfg_wdata;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     i_command;
    logic [SLOT_W-1:0]    i_slot_index;
    logic                 o_strobe;
    logic [SLOT_W-1:0]    o_granted_slot;
    logic [STAT_W-1:0]    o_status;
    logic [COUNT_W-1:0]   o_in_use_count;

    dense_slot_allocator_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_slot_index   (i_slot_index),
        .o_strobe       (o_strobe),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status),
        .o_in_use_count (o_in_use_count)
    );

    // Shadow copy of the allocator's state. The order table is a permutation of all slots whose
    // first used_cnt entries are the slots handed out; the position table is its inverse.
    logic [SLOT_W-1:0]  order_tbl [NUM_SLOTS];
    logic [SLOT_W-1:0]  pos_tbl   [NUM_SLOTS];
    bit                 free_flag [NUM_SLOTS];
    logic [COUNT_W-1:0] used_cnt;
    logic [POOL_W-1:0]  pool_reg;

    t_alloc_outcome owed_outcomes [$];
    t_alloc_outcome head_outcome;
    t_script_row    script [SCRIPT_LEN];

    int unsigned fault_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A clear always rebuilds every entry, whatever the pool size is set to.
    function automatic void clear_tables();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            order_tbl[i] = SLOT_W'(i);
            pos_tbl[i]   = SLOT_W'(i);
            free_flag[i] = 1'b1;
        end
        used_cnt = '0;
    endfunction

    // Applies one command to the shadow state and returns the result beat it should produce.
    function automatic t_alloc_outcome apply_command(logic [CMD_W-1:0] cmd,
                                                     logic [SLOT_W-1:0] slot);
        t_alloc_outcome     res;
        logic [POOL_W:0]    size;
        logic [SLOT_W-1:0]  pick;
        logic [SLOT_W-1:0]  hole;
        logic [SLOT_W-1:0]  last;
        logic [SLOT_W-1:0]  mover;
        res.granted = '0;
        res.status  = ST_OK;
        // The register is clamped into 1..NUM_SLOTS before use.
        size = {1'b0, pool_reg};
        if (size == 0) begin
            size = (POOL_W+1)'(1);
        end else if (size > NUM_SLOTS) begin
            size = (POOL_W+1)'(NUM_SLOTS);
        end
        case (cmd)
            CMD_ALLOC: begin
                if ({1'b0, used_cnt} >= size) begin
                    res.status = ST_FULL;
                end else begin
                    pick = order_tbl[used_cnt[SLOT_W-1:0]];
                    free_flag[pick] = 1'b0;
                    pos_tbl[pick]   = used_cnt[SLOT_W-1:0];
                    used_cnt        = used_cnt + 1'b1;
                    res.granted     = pick;
                end
            end
            CMD_FREE: begin
                if ({2'b00, slot} >= size) begin
                    res.status = ST_RANGE;
                end else if (free_flag[slot] || used_cnt == 0) begin
                    res.status = ST_ALREADY;
                end else begin
                    // Move the last allocated slot into the hole and park the freed one at the
                    // end of the allocated region.
                    hole  = pos_tbl[slot];
                    last  = SLOT_W'(used_cnt - 1'b1);
                    mover = order_tbl[last];
                    free_flag[slot] = 1'b1;
                    order_tbl[last] = slot;
                    pos_tbl[slot]   = last;
                    order_tbl[hole] = mover;
                    pos_tbl[mover]  = hole;
                    used_cnt        = used_cnt - 1'b1;
                end
            end
            CMD_CLEAR: begin
                clear_tables();
            end
            default: begin
            end
        endcase
        res.count = used_cnt;
        return res;
    endfunction

    function automatic t_script_row cfg_row(logic [POOL_W-1:0] value);
        t_script_row row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        return row;
    endfunction

    function automatic t_script_row op_row(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot);
        t_script_row row;
        row = '0;
        row.cmd  = cmd;
        row.slot = slot;
        return row;
    endfunction

    function automatic t_script_row chk_row(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                            logic [SLOT_W-1:0] granted, t_status status,
                                            logic [COUNT_W-1:0] count);
        t_script_row row;
        row = op_row(cmd, slot);
        row.typed        = 1'b1;
        row.want.granted = granted;
        row.want.status  = status;
        row.want.count   = count;
        return row;
    endfunction

    // Presents one command beat and holds it until the block takes it. The expectation is
    // queued at the accepting edge, so it is always ahead of the matching result strobe.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                         input bit typed, input t_alloc_outcome typed_val);
        t_alloc_outcome predicted;
        i_command    <= cmd;
        i_slot_index <= slot;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = apply_command(cmd, slot);
        owed_outcomes.push_back(typed ? typed_val : predicted);
    endtask

    // Drops start for a number of cycles, with junk on the command fields meanwhile. A gap of
    // zero leaves start high so that the next beat follows back to back.
    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0) begin
            start        <= 1'b0;
            i_command    <= CMD_W'($urandom_range(0, 3));
            i_slot_index <= SLOT_W'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // The pool size is only written once the block has gone quiet. Every command produces a
    // result, so an empty queue with busy low means nothing is in flight; spare idle cycles
    // are let pass all the same.
    task automatic write_pool_size(input logic [POOL_W-1:0] value);
        start <= 1'b0;
        while (owed_outcomes.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pool_reg = value;
    endtask

    // Result checker. Every strobe must line up with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (owed_outcomes.size() == 0) begin
                $error("result beat with nothing expected: granted_slot %0d status %0d count %0d",
                       o_granted_slot, o_status, o_in_use_count);
                fault_count++;
            end else begin
                head_outcome = owed_outcomes.pop_front();
                if (o_granted_slot !== head_outcome.granted) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           head_outcome.granted, o_granted_slot);
                    fault_count++;
                end
                if (o_status !== head_outcome.status) begin
                    $error("status: expected %0d, actual %0d", head_outcome.status, o_status);
                    fault_count++;
                end
                if (o_in_use_count !== head_outcome.count) begin
                    $error("in_use_count: expected %0d, actual %0d",
                           head_outcome.count, o_in_use_count);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dense_slot_allocator_core: mismatch");
            $finish;
        end
    end

    initial begin
        t_alloc_outcome    no_value;
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [POOL_W-1:0] size_value;
        int unsigned       phase_items;
        int unsigned       alloc_pct;
        int unsigned       clear_pct;
        int unsigned       draw;
        bit                no_idle;

        fault_count  = 0;
        cycle_count  = 0;
        no_value     = '0;
        no_idle      = 1'b0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        start        <= 1'b0;
        i_command    <= CMD_ALLOC;
        i_slot_index <= '0;
        pool_reg     = POOL_SIZE_RST;
        clear_tables();

        // Directed script. From reset the tables are the identity, so the first grants and
        // the error codes can be written down directly; the rest goes through the predictor.
        script[0]  = chk_row(CMD_FREE,   8'd0,   8'd0, ST_ALREADY, 9'd0);  // free on empty pool
        script[1]  = chk_row(CMD_ALLOC,  8'd0,   8'd0, ST_OK,      9'd1);
        script[2]  = chk_row(CMD_ALLOC,  8'd0,   8'd1, ST_OK,      9'd2);
        script[3]  = chk_row(CMD_FREE,   8'd0,   8'd0, ST_OK,      9'd1);
        script[4]  = chk_row(CMD_FREE,   8'd0,   8'd0, ST_ALREADY, 9'd1);  // double free
        script[5]  = op_row(CMD_ALLOC,   8'hFF);                           // slot is ignored
        script[6]  = op_row(CMD_FREE,    8'd1);
        script[7]  = chk_row(CMD_UNUSED, 8'hFF,  8'd0, ST_OK,      9'd1);
        script[8]  = chk_row(CMD_FREE,   8'hFF,  8'd0, ST_ALREADY, 9'd1);
        script[9]  = chk_row(CMD_CLEAR,  8'hAA,  8'd0, ST_OK,      9'd0);
        script[10] = cfg_row(9'd0);                                        // clamps up to one
        script[11] = chk_row(CMD_ALLOC,  8'd0,   8'd0, ST_OK,      9'd1);
        script[12] = chk_row(CMD_ALLOC,  8'd0,   8'd0, ST_FULL,    9'd1);
        script[13] = chk_row(CMD_FREE,   8'd1,   8'd0, ST_RANGE,   9'd1);
        script[14] = chk_row(CMD_FREE,   8'd0,   8'd0, ST_OK,      9'd0);
        script[15] = cfg_row(9'd511);                                      // clamps down
        script[16] = op_row(CMD_ALLOC,   8'd0);
        script[17] = op_row(CMD_ALLOC,   8'd0);
        script[18] = op_row(CMD_ALLOC,   8'd0);
        script[19] = op_row(CMD_FREE,    8'd0);
        script[20] = op_row(CMD_FREE,    8'd2);
        // Shrinking without a clear: the next grant lies beyond the new size and cannot be
        // returned until the pool is cleared.
        script[21] = cfg_row(9'd2);
        script[22] = op_row(CMD_ALLOC,   8'd0);
        script[23] = chk_row(CMD_FREE,   8'd2,   8'd0, ST_RANGE,   9'd2);
        script[24] = chk_row(CMD_ALLOC,  8'd0,   8'd0, ST_FULL,    9'd2);
        script[25] = chk_row(CMD_CLEAR,  8'd0,   8'd0, ST_OK,      9'd0);
        script[26] = cfg_row(9'd256);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its tables after reset with busy high; the first beat simply waits
        // for it, as does the first write below.
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (script[r].is_cfg) begin
                write_pool_size(script[r].cfg_value);
            end else begin
                issue(script[r].cmd, script[r].slot, script[r].typed, script[r].want);
                idle_for($urandom_range(0, 18));
            end
        end

        // Random phases, each under its own pool size. The first fills the full pool without
        // clears so that the full condition is reached at the largest size; middle ones mix
        // allocate and free about evenly. Most frees name a slot that is really allocated,
        // which keeps the swap path busy; the rest name any slot and mostly hit the error codes.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       size_value = 9'd256;
                1:       size_value = POOL_W'($urandom_range(1, 16));
                2:       size_value = 9'd0;
                3:       size_value = 9'd511;
                4:       size_value = POOL_W'($urandom_range(257, 510));
                5:       size_value = POOL_W'($urandom_range(3, 255));
                6:       size_value = 9'd2;
                default: size_value = 9'd256;
            endcase
            write_pool_size(size_value);
            // A clear usually follows a size change, but not always, so that slots left
            // beyond a shrunken pool are exercised too.
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
                issue(CMD_CLEAR, SLOT_W'($urandom), 1'b0, no_value);
            end

            phase_items = (phase == 0) ? 340 : 180;
            alloc_pct   = (phase == 0) ? 90 : ((phase == NUM_PHASES - 1) ? 70 : 50);
            clear_pct   = (phase == 0) ? 0 : 1;

            for (int n = 0; n < phase_items; n++) begin
                // Runs of back-to-back beats are switched on and off now and then.
                if (n % 32 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                slot = SLOT_W'($urandom);
                draw = $urandom_range(0, 99);
                if (draw < clear_pct) begin
                    cmd = CMD_CLEAR;
                end else if (draw < clear_pct + 2) begin
                    cmd = CMD_UNUSED;
                end else if (draw < clear_pct + 2 + alloc_pct) begin
                    cmd = CMD_ALLOC;
                end else begin
                    cmd = CMD_FREE;
                    if (used_cnt != 0 && $urandom_range(0, 99) < 85) begin
                        slot = order_tbl[$urandom_range(0, used_cnt - 1)];
                    end
                end
                issue(cmd, slot, 1'b0, no_value);
                idle_for(no_idle ? 0 : $urandom_range(0, 18));
            end
        end

        // Drain, then leave room for a stray strobe to show up.
        start <= 1'b0;
        while (owed_outcomes.size() != 0) @(posedge i_clk);
        repeat (NUM_SLOTS + 8) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("dense_slot_allocator_core: match");
        end else begin
            $display("dense_slot_allocator_core: mismatch");
        end
        $finish;
    end

endmodule
